// ----- rtl/core/snco_pkg.sv -----
// shared constants, types and quarter-wave table builder for the sine nco
package snco_pkg;

	// datapath sizing
	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	// configuration register widths
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DELAY_BITS    = 24;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_BITS  = 8;
	localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	// command queue between front and back
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	// quarter-wave table
	localparam int TAB_N = 1 << TABLE_ADDR_BITS;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
	localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

	// taylor series divisors (2n)(2n+1)
	localparam logic [63:0] SIN_D1 = 64'd6;
	localparam logic [63:0] SIN_D2 = 64'd20;
	localparam logic [63:0] SIN_D3 = 64'd42;
	localparam logic [63:0] SIN_D4 = 64'd72;
	localparam logic [63:0] SIN_D5 = 64'd110;
	localparam logic [63:0] SIN_D6 = 64'd156;
	localparam logic [63:0] SIN_D7 = 64'd210;
	localparam logic [63:0] SIN_D8 = 64'd272;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PHASE_INC   = 2'd0,
		REG_START_PHASE = 2'd1,
		REG_JUMP_DELAY  = 2'd2,
		REG_JUMP_OFFSET = 2'd3
	} reg_idx_t;

	// command kinds produced by the front
	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] phase_inc;
		logic [CFG_DATA_BITS-1:0] start_phase;
		logic [DELAY_BITS-1:0]    jump_delay;
		logic [CFG_DATA_BITS-1:0] jump_offset;
	} cfg_t;

	// front to queue
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	// queue to back
	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} q_rd_t;

	typedef logic [SAMPLE_BITS-2:0] qtab_t [TAB_N + 1];

	// 32 bit register value as the top bits of the phase word
	function automatic logic [PHASE_BITS-1:0] to_phase(input logic [CFG_DATA_BITS-1:0] v);
		logic [PHASE_BITS+CFG_DATA_BITS-1:0] w;
		w = {v, {PHASE_BITS{1'b0}}};
		return w[PHASE_BITS+CFG_DATA_BITS-1 -: PHASE_BITS];
	endfunction

	// sine in q30 by truncated taylor series, elaboration only
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / SIN_D1;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / SIN_D2;
		sum  = sum + term;
		term = ((term * x2) >> 30) / SIN_D3;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / SIN_D4;
		sum  = sum + term;
		term = ((term * x2) >> 30) / SIN_D5;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / SIN_D6;
		sum  = sum + term;
		term = ((term * x2) >> 30) / SIN_D7;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / SIN_D8;
		sum  = sum + term;
		return sum;
	endfunction

	// quarter-wave table contents, entries 0 through TAB_N
	function automatic qtab_t build_qtab();
		qtab_t       t;
		logic [63:0] x;
		logic [63:0] v;
		for (int k = 0; k <= TAB_N; k++) begin
			x = (HALF_PI_Q30 * 64'(k)) / TAB_N;
			v = (AMP * sin_q30(x) + HALF_Q30) >> 30;
			if (v > AMP) begin
				v = AMP;
			end
			t[k] = v[SAMPLE_BITS-2:0];
		end
		return t;
	endfunction

endpackage

// ----- rtl/core/sine_nco_with_phase_jump_unit.sv -----
// top level of the sine nco with one-time phase jump
//
// Each input beat (bit 0 of s_tdata = restart) yields one output beat carrying
// the signed Q1.15 sine of the current phase in m_tdata[15:0]; the phase then
// advances by phase_increment. A restart beat first reloads the phase from
// start_phase and the countdown from jump_delay. The countdown drops once per
// beat and, on the beat where it reaches zero, jump_offset is added to the
// phase once; a delay of zero means no jump. Registers are written through
// cfg_we/cfg_addr/cfg_wdata (0 phase_increment, 1 start_phase, 2 jump_delay,
// 3 jump_offset). start_phase and jump_delay take effect at the next restart;
// the increment applies from the next beat and the offset is read when the
// jump happens. Throughput is one beat per clock while m_tready stays high. A
// result passes the two-entry command queue, written at the accepting edge,
// then the registered accumulator update with table address, then the
// registered quarter-wave table read, which is the output register that
// drives m_tdata and m_tvalid. Input acceptance stalls only when the queue
// is full.
module sine_nco_with_phase_jump_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [snco_pkg::CFG_IDX_BITS-1:0]       cfg_addr,
	input  logic [snco_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [snco_pkg::IN_TDATA_BITS-1:0]      s_tdata,   // [0] restart
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [snco_pkg::OUT_TDATA_BITS-1:0]     m_tdata    // [15:0] sample
);

	snco_pkg::cfg_t  cfg_q;
	snco_pkg::q_wr_t q_wr;
	snco_pkg::q_rd_t q_rd;
	logic            q_full;
	logic            pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (snco_pkg::reg_idx_t'(cfg_addr))
				snco_pkg::REG_PHASE_INC:   cfg_q.phase_inc   <= cfg_wdata;
				snco_pkg::REG_START_PHASE: cfg_q.start_phase <= cfg_wdata;
				snco_pkg::REG_JUMP_DELAY:
					cfg_q.jump_delay <= cfg_wdata[snco_pkg::DELAY_BITS-1:0];
				snco_pkg::REG_JUMP_OFFSET: cfg_q.jump_offset <= cfg_wdata;
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	// input classification
	snco_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	// command queue
	snco_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_full (q_full),
		.q_rd   (q_rd)
	);

	// oscillator and output
	snco_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_rd     (q_rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- rtl/core/snco_front.sv -----
// input side: takes beats and turns them into tick or restart commands
module snco_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [snco_pkg::IN_TDATA_BITS-1:0]     s_tdata,   // [0] restart, rest zero
	input  logic                                   q_full,
	output snco_pkg::q_wr_t                        q_wr
);

	// accept whenever the queue has a free slot
	assign s_tready = !q_full;

	// classify the beat
	always_comb begin
		q_wr.push = s_tvalid && !q_full;
		q_wr.cmd  = s_tdata[0] ? snco_pkg::CMD_RESTART : snco_pkg::CMD_TICK;
	end

	property p_no_push_when_full;
		@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr.push;
	endproperty
	a_no_push_when_full: assert property (p_no_push_when_full)
		else $error("push while queue full");

	property p_accept_is_push;
		@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> q_wr.push;
	endproperty
	a_accept_is_push: assert property (p_accept_is_push)
		else $error("accepted beat not queued");

	property p_cmd_matches_flag;
		@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> ((q_wr.cmd == snco_pkg::CMD_RESTART) == s_tdata[0]);
	endproperty
	a_cmd_matches_flag: assert property (p_cmd_matches_flag)
		else $error("command kind does not match restart flag");

endmodule

// ----- rtl/core/snco_queue.sv -----
// short command queue between front and back
module snco_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  snco_pkg::q_wr_t q_wr,
	input  logic            pop,
	output logic            q_full,
	output snco_pkg::q_rd_t q_rd
);

	snco_pkg::cmd_t                      slot_q [snco_pkg::Q_DEPTH];
	logic [snco_pkg::Q_PTR_BITS-1:0]     wr_ptr_q;
	logic [snco_pkg::Q_PTR_BITS-1:0]     rd_ptr_q;
	logic [snco_pkg::Q_CNT_BITS-1:0]     cnt_q;
	logic                                do_push;
	logic                                do_pop;

	localparam logic [snco_pkg::Q_PTR_BITS-1:0] LAST_PTR =
		snco_pkg::Q_PTR_BITS'(snco_pkg::Q_DEPTH - 1);
	localparam logic [snco_pkg::Q_CNT_BITS-1:0] FULL_CNT =
		snco_pkg::Q_CNT_BITS'(snco_pkg::Q_DEPTH);

	assign q_full   = (cnt_q == FULL_CNT);
	assign q_rd.avail = (cnt_q != '0);
	assign q_rd.cmd   = slot_q[rd_ptr_q];
	assign do_push  = q_wr.push && !q_full;
	assign do_pop   = pop && q_rd.avail;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

	property p_cnt_bounded;
		@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT;
	endproperty
	a_cnt_bounded: assert property (p_cnt_bounded)
		else $error("queue count out of range");

	property p_pop_only_avail;
		@(posedge clk) disable iff (!arst_n)
		pop |-> q_rd.avail;
	endproperty
	a_pop_only_avail: assert property (p_pop_only_avail)
		else $error("pop from empty queue");

	property p_count_tracks;
		@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1);
	endproperty
	a_count_tracks: assert property (p_count_tracks)
		else $error("queue count did not follow push");

endmodule

// ----- rtl/core/snco_back.sv -----
// back end: phase accumulator, one-time jump, table lookup and output register
module snco_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  snco_pkg::cfg_t                       cfg,
	input  snco_pkg::q_rd_t                      q_rd,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [snco_pkg::OUT_TDATA_BITS-1:0]  m_tdata    // [15:0] sample
);

	localparam int PB = snco_pkg::PHASE_BITS;
	localparam int AB = snco_pkg::TABLE_ADDR_BITS;
	localparam int SB = snco_pkg::SAMPLE_BITS;
	localparam logic [AB:0] TAB_N_IDX = (AB + 1)'(snco_pkg::TAB_N);
	localparam snco_pkg::qtab_t QTAB = snco_pkg::build_qtab();

	// oscillator state
	logic [PB-1:0]                       acc_q;
	logic [snco_pkg::DELAY_BITS-1:0]     cnt_q;
	logic                                done_q;

	// next-state and lookup terms
	logic                                restart;
	logic [PB-1:0]                       cur_phase;
	logic [snco_pkg::DELAY_BITS-1:0]     cur_cnt;
	logic                                cur_done;
	logic [snco_pkg::DELAY_BITS-1:0]     nxt_cnt;
	logic                                nxt_done;
	logic                                jump;
	logic [PB-1:0]                       nxt_acc;
	logic [1:0]                          quad;
	logic [AB-1:0]                       tab_i;
	logic [AB:0]                         idx;

	// pipeline
	logic                                adv;
	logic                                valid_s1;
	logic [AB:0]                         idx_s1;
	logic                                neg_s1;
	logic                                valid_s2;
	logic [SB-2:0]                       mag_s2;
	logic                                neg_s2;
	logic [SB-1:0]                       mag_ext;
	logic [SB-1:0]                       sample;

	assign adv = !valid_s2 || m_tready;
	assign pop = q_rd.avail && adv;

	// phase, countdown and jump for the command at the head of the queue
	always_comb begin
		restart   = (q_rd.cmd == snco_pkg::CMD_RESTART);
		cur_phase = restart ? snco_pkg::to_phase(cfg.start_phase) : acc_q;
		cur_cnt   = restart ? cfg.jump_delay : cnt_q;
		cur_done  = restart ? 1'b0 : done_q;
		nxt_cnt   = cur_cnt;
		nxt_done  = cur_done;
		jump      = 1'b0;
		if (!cur_done && (cur_cnt != '0)) begin
			nxt_cnt = cur_cnt - 1'b1;
			if (nxt_cnt == '0) begin
				jump     = 1'b1;
				nxt_done = 1'b1;
			end
		end
		nxt_acc = cur_phase + snco_pkg::to_phase(cfg.phase_inc)
			+ (jump ? snco_pkg::to_phase(cfg.jump_offset) : {PB{1'b0}});
		quad  = cur_phase[PB-1 -: 2];
		tab_i = cur_phase[PB-3 -: AB];
		idx   = quad[0] ? (TAB_N_IDX - {1'b0, tab_i}) : {1'b0, tab_i};
	end

	// state and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= snco_pkg::to_phase('0);
			cnt_q    <= '0;
			done_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop) begin
				acc_q  <= nxt_acc;
				cnt_q  <= nxt_cnt;
				done_q <= nxt_done;
			end
			if (adv) begin
				valid_s1 <= q_rd.avail;
				valid_s2 <= valid_s1;
			end
		end
	end

	// table address stage and registered table read
	always_ff @(posedge clk) begin
		if (pop) begin
			idx_s1 <= idx;
			neg_s1 <= quad[1];
		end
		if (adv && valid_s1) begin
			mag_s2 <= QTAB[idx_s1];
			neg_s2 <= neg_s1;
		end
	end

	// sign by half-turn, zero padded to the beat width
	assign mag_ext  = {1'b0, mag_s2};
	assign sample   = neg_s2 ? (~mag_ext + 1'b1) : mag_ext;
	assign m_tvalid = valid_s2;
	assign m_tdata  = snco_pkg::OUT_TDATA_BITS'(sample);

	property p_done_means_zero_count;
		@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0);
	endproperty
	a_done_means_zero_count: assert property (p_done_means_zero_count)
		else $error("jump done with countdown still running");

	property p_s1_holds_on_stall;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(idx_s1) && $stable(neg_s1));
	endproperty
	a_s1_holds_on_stall: assert property (p_s1_holds_on_stall)
		else $error("table address stage changed during stall");

	property p_idx_in_range;
		@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_s1 <= TAB_N_IDX);
	endproperty
	a_idx_in_range: assert property (p_idx_in_range)
		else $error("table index past end of quarter wave");

	property p_state_only_on_pop;
		@(posedge clk) disable iff (!arst_n)
		!pop |=> ($stable(acc_q) && $stable(cnt_q) && $stable(done_q));
	endproperty
	a_state_only_on_pop: assert property (p_state_only_on_pop)
		else $error("oscillator state moved without a command");

endmodule

// ----- tb/tb_sine_nco_with_phase_jump_unit.sv -----
// testbench for the sine nco: random restart beats checked against a local phase and sine model
`timescale 1ns / 100ps

module tb_sine_nco_with_phase_jump_unit;

	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          RANDOM_BEATS   = 1700;
	localparam logic [63:0] QTR_TURN_Q30   = 64'd1686629713;
	localparam logic [63:0] PEAK           = (64'd1 << (snco_pkg::SAMPLE_BITS - 1)) - 64'd1;
	localparam logic [63:0] ROUND_Q30      = 64'd1 << 29;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_THREE_OF_FOUR,
		RX_HALF
	} rx_mode_t;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 cfg_we    = 1'b0;
	logic [snco_pkg::CFG_IDX_BITS-1:0]    cfg_addr  = '0;
	logic [snco_pkg::CFG_DATA_BITS-1:0]   cfg_wdata = '0;
	logic                                 s_tvalid  = 1'b0;
	logic                                 s_tready;
	logic [snco_pkg::IN_TDATA_BITS-1:0]   s_tdata   = '0;   // [0] restart
	logic                                 m_tvalid;
	logic                                 m_tready  = 1'b0;
	logic [snco_pkg::OUT_TDATA_BITS-1:0]  m_tdata;          // [15:0] sample

	// register copies used by the sample predictor
	logic [31:0]                     inc_reg    = '0;
	logic [31:0]                     start_reg  = '0;
	logic [snco_pkg::DELAY_BITS-1:0] delay_reg  = '0;
	logic [31:0]                     offset_reg = '0;

	// oscillator state copy
	logic [snco_pkg::PHASE_BITS-1:0] nco_phase  = '0;
	logic [snco_pkg::DELAY_BITS-1:0] jump_cnt   = '0;
	logic                            jump_taken = 1'b0;

	logic [snco_pkg::SAMPLE_BITS-2:0] sine_rom [0:snco_pkg::TAB_N];

	logic                             restart_queue [$];
	logic [snco_pkg::SAMPLE_BITS-1:0] exp_samples [$];

	int unsigned burst_left  = 0;
	int unsigned gap_left    = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches  = 0;
	logic [15:0] rx_cyc      = '0;
	rx_mode_t    rx_mode     = RX_ALWAYS;

	sine_nco_with_phase_jump_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// 32 bit register value placed at the top of the phase word
	function automatic logic [snco_pkg::PHASE_BITS-1:0] reg_to_phase(input logic [31:0] v);
		logic [63:0] w;
		w = {32'd0, v};
		if (snco_pkg::PHASE_BITS >= 32) begin
			w = w << (snco_pkg::PHASE_BITS - 32);
		end else begin
			w = w >> (32 - snco_pkg::PHASE_BITS);
		end
		return w[snco_pkg::PHASE_BITS-1:0];
	endfunction

	// one tick of the oscillator: sample of the current phase, then phase and jump update
	function automatic logic [snco_pkg::SAMPLE_BITS-1:0] advance_nco(input logic restart);
		logic [1:0]                           quad;
		logic [snco_pkg::TABLE_ADDR_BITS-1:0] idx;
		logic [snco_pkg::SAMPLE_BITS-1:0]     mag;
		if (restart) begin
			nco_phase  = reg_to_phase(start_reg);
			jump_cnt   = delay_reg;
			jump_taken = 1'b0;
		end
		quad = nco_phase[snco_pkg::PHASE_BITS-1 -: 2];
		idx  = nco_phase[snco_pkg::PHASE_BITS-3 -: snco_pkg::TABLE_ADDR_BITS];
		// odd quadrants read the table mirrored, the lower half is negated
		mag  = quad[0] ? {1'b0, sine_rom[snco_pkg::TAB_N - idx]} : {1'b0, sine_rom[idx]};
		nco_phase = nco_phase + reg_to_phase(inc_reg);
		if (!jump_taken && jump_cnt != '0) begin
			jump_cnt = jump_cnt - 1'b1;
			if (jump_cnt == '0) begin
				nco_phase  = nco_phase + reg_to_phase(offset_reg);
				jump_taken = 1'b1;
			end
		end
		return quad[1] ? -mag : mag;
	endfunction

	// sender: bursts of beats with random gaps, expectation made at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				exp_samples.insert(exp_samples.size(), advance_nco(s_tdata[0]));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (restart_queue.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {{(snco_pkg::IN_TDATA_BITS-1){1'b0}},
						restart_queue.pop_front()};
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern picked at random when the cycle counter's low byte wraps, each sample beat checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cyc   <= '0;
			rx_mode  <= RX_ALWAYS;
		end else begin
			rx_cyc <= rx_cyc + 1'b1;
			if (rx_cyc[7:0] == 8'hFF) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			end
			case (rx_mode)
				RX_ALWAYS:        m_tready <= 1'b1;
				RX_RANDOM:        m_tready <= ($urandom_range(0, 3) != 0);
				RX_THREE_OF_FOUR: m_tready <= (rx_cyc[1:0] != 2'b11);
				default:          m_tready <= rx_cyc[2];
			endcase
			if (m_tvalid && m_tready) begin
				if (exp_samples.size() == 0) begin
					if (mismatches < 10) begin
						$display("unexpected sample beat: got %0d",
							$signed(m_tdata[snco_pkg::SAMPLE_BITS-1:0]));
					end
					mismatches <= mismatches + 1;
				end else if (m_tdata[snco_pkg::SAMPLE_BITS-1:0] !== exp_samples[0]) begin
					if (mismatches < 10) begin
						$display("sample mismatch: expected %0d, got %0d",
							$signed(exp_samples[0]),
							$signed(m_tdata[snco_pkg::SAMPLE_BITS-1:0]));
					end
					mismatches <= mismatches + 1;
					void'(exp_samples.pop_front());
				end else begin
					void'(exp_samples.pop_front());
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// wait until every queued beat has been sent and every sample has come back
	task automatic drain();
		while (restart_queue.size() != 0 || s_tvalid || exp_samples.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// queue count restart flags, lowest bit first
	task automatic push_beats(input logic [31:0] pattern, input int count);
		for (int b = 0; b < count; b++) begin
			restart_queue.insert(restart_queue.size(), pattern[b]);
		end
	endtask

	task automatic write_reg(input snco_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			snco_pkg::REG_PHASE_INC:   inc_reg    = val;
			snco_pkg::REG_START_PHASE: start_reg  = val;
			snco_pkg::REG_JUMP_DELAY:  delay_reg  = val[snco_pkg::DELAY_BITS-1:0];
			default:                   offset_reg = val;
		endcase
	endtask

	// write the selected registers once the block has gone idle
	task automatic configure(input logic [3:0] sel, input logic [31:0] inc,
		input logic [31:0] start, input logic [31:0] dly, input logic [31:0] ofs);
		drain();
		if (sel[snco_pkg::REG_PHASE_INC]) begin
			write_reg(snco_pkg::REG_PHASE_INC, inc);
		end
		if (sel[snco_pkg::REG_START_PHASE]) begin
			write_reg(snco_pkg::REG_START_PHASE, start);
		end
		if (sel[snco_pkg::REG_JUMP_DELAY]) begin
			write_reg(snco_pkg::REG_JUMP_DELAY, dly);
		end
		if (sel[snco_pkg::REG_JUMP_OFFSET]) begin
			write_reg(snco_pkg::REG_JUMP_OFFSET, ofs);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] v;
		logic [31:0] r_inc;
		logic [31:0] r_start;
		logic [31:0] r_dly;
		logic [31:0] r_ofs;
		int          n_beats;
		int          beats_sent;

		// quarter-wave table: taylor sine in q30, scaled and rounded
		for (int k = 0; k <= snco_pkg::TAB_N; k++) begin
			x    = (QTR_TURN_Q30 * 64'(k)) / 64'(snco_pkg::TAB_N);
			x2   = (x * x) >> 30;
			term = x;
			acc  = x;
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = (acc >= term) ? acc - term : 64'd0;
				end else begin
					acc = acc + term;
				end
			end
			v = (PEAK * acc + ROUND_Q30) >> 30;
			if (v > PEAK) begin
				v = PEAK;
			end
			sine_rom[k] = v[snco_pkg::SAMPLE_BITS-2:0];
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state: phase zero and no jump armed
		push_beats(32'b100, 3);
		// quarter-turn steps land on each quadrant boundary
		configure(4'b1111, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_beats(32'b00001, 5);
		// half-turn step, top start phase, jump applied on the restart beat itself
		configure(4'b1111, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		push_beats(32'b001, 3);
		// frozen phase and the longest delay, upper write bits ignored
		configure(4'b1111, 32'h0000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
		push_beats(32'b01, 2);
		// jump on the third beat counting the restart, restart re-arms it
		configure(4'b1111, 32'h0100_0000, 32'h0000_0000, 32'h0000_0003, 32'h4000_0000);
		push_beats(32'b00001_00001, 10);

		// random phases of settings, mostly restart followed by a run of ticks
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			case ($urandom_range(0, 5))
				0:       r_inc = 32'h0000_0000;
				1:       r_inc = 32'h8000_0000;
				2, 3:    r_inc = $urandom_range(0, 32'h00FF_FFFF);
				default: r_inc = $urandom_range(0, 32'h8000_0000);
			endcase
			case ($urandom_range(0, 5))
				0:       r_start = 32'h0000_0000;
				1:       r_start = 32'hFFFF_FFFF;
				default: r_start = $urandom();
			endcase
			case ($urandom_range(0, 7))
				0:       r_dly = {8'($urandom()), 24'h00_0000};
				1:       r_dly = {8'($urandom()), 24'hFF_FFFF};
				2:       r_dly = {8'($urandom()), 24'($urandom_range(1, 24'hFF_FFFF))};
				default: r_dly = {8'($urandom()), 24'($urandom_range(1, 64))};
			endcase
			case ($urandom_range(0, 5))
				0:       r_ofs = 32'h0000_0000;
				1:       r_ofs = 32'hFFFF_FFFF;
				default: r_ofs = $urandom();
			endcase
			configure(4'($urandom()), r_inc, r_start, r_dly, r_ofs);
			n_beats = $urandom_range(10, 120);
			restart_queue.insert(restart_queue.size(), $urandom_range(0, 7) != 0);
			for (int b = 1; b < n_beats; b++) begin
				restart_queue.insert(restart_queue.size(), $urandom_range(0, 24) == 0);
			end
			beats_sent = beats_sent + n_beats;
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && exp_samples.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/snco_pkg.sv
rtl/core/snco_front.sv
rtl/core/snco_queue.sv
rtl/core/snco_back.sv
rtl/core/sine_nco_with_phase_jump_unit.sv
tb/tb_sine_nco_with_phase_jump_unit.sv
